// File: hw/rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// widths, entry flag bits and controller states of the page table mapper
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

  localparam int VPN_W    = 36;
  localparam int FRAME_W  = 40;
  localparam int ENTRY_W  = 64;
  localparam int IDX_W    = 9;
  localparam int COUNT_W  = 2;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int PAGE_SHIFT = 12;

  localparam int ENT_P_BIT  = 0;
  localparam int ENT_RW_BIT = 1;
  localparam int ENT_US_BIT = 2;
  localparam int ENT_PS_BIT = 7;

  localparam logic [ENTRY_W-1:0] TABLE_LINK_FLAGS =
    ENTRY_W'((64'd1 << ENT_P_BIT) | (64'd1 << ENT_RW_BIT) | (64'd1 << ENT_US_BIT));
  localparam logic [ENTRY_W-1:0] LEAF_FLAG_MASK = ~(ENTRY_W'(1) << ENT_PS_BIT);

  localparam logic [1:0] LVL_LAST_UPPER = 2'd2;
  localparam logic [1:0] LVL_COUNT = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_LINK,
    S_LEAF,
    S_RESP
  } ptm_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ptm_ifs.sv
// ----------------------------------------------------------------------------
// ptm_ifs
// request and response channels of the page table mapper
// ----------------------------------------------------------------------------
`default_nettype none

interface ptm_req_if;
  import ptm_pkg::*;

  logic               valid;
  logic               ready;
  logic [VPN_W-1:0]   virt_page;
  logic [FRAME_W-1:0] phys_frame;
  logic [ENTRY_W-1:0] leaf_flags;

  modport source (output valid, output virt_page, output phys_frame,
                  output leaf_flags, input ready);
  modport sink   (input valid, input virt_page, input phys_frame,
                  input leaf_flags, output ready);
endinterface

interface ptm_rsp_if;
  import ptm_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [COUNT_W-1:0] new_tables;
  logic [ENTRY_W-1:0] leaf_entry;

  modport source (output valid, output status, output new_tables,
                  output leaf_entry, input ready);
  modport sink   (input valid, input status, input new_tables,
                  input leaf_entry, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/four_level_page_table_mapper.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// maps one 4 KiB page per item into a four-level radix table kept on chip
// ----------------------------------------------------------------------------
// req carries virt_page, phys_frame and leaf_flags; rsp returns status,
// new_tables and leaf_entry, one rsp item per req item, in order.
// cfg_wr_en / cfg_wr_data load the root table frame; the user must load
// it only while the block is idle; the block does not enforce it. after
// reset the store is swept to zero, one entry a cycle, with req.ready low.
// one item at a time goes through the walk; all of it runs on the table
// store's one read and one write address (a read is issued, then checked):
//   each upper entry read and checked in turn, up to the first missing one
//   missing table: one link write per level from the first missing one
//   leaf write, then result load; an error goes straight to the result load
// all of this follows the accept of the item in the idle state.
// the result sits in an output register; a stalled rsp holds it, and the
// next req item is taken meanwhile, stopping only when its own result
// is ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_mapper #(
  parameter int TABLE_PAGES = 64
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_wr_en,
  input  wire [ptm_pkg::FRAME_W-1:0]  cfg_wr_data,
  ptm_req_if.sink                     req,
  ptm_rsp_if.source                   rsp
);
  import ptm_pkg::*;

  localparam int SLOT_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int CNT_W   = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int DEPTH   = TABLE_PAGES * ENTRIES_PER_TABLE;

  ptm_state_t state, state_next;

  logic [ENTRY_W-1:0] table_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [FRAME_W-1:0] base_frame;
  logic [CNT_W-1:0]   next_free;
  logic [ADDR_W-1:0]  clr_addr;

  logic [VPN_W-1:0]   vpn;
  logic [FRAME_W-1:0] frame;
  logic [ENTRY_W-1:0] flags;
  logic [1:0]         lvl;
  logic [SLOT_W-1:0]  cur;
  logic [COUNT_W-1:0] need;
  logic               err;

  logic               out_valid;
  logic               out_status;
  logic [COUNT_W-1:0] out_new_tables;
  logic [ENTRY_W-1:0] out_leaf;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [IDX_W-1:0]   lvl_idx;
  logic               ent_present;
  logic [FRAME_W-1:0] rel;
  logic               slot_ok;
  logic [COUNT_W-1:0] miss_count;
  logic               pool_ok;
  logic [FRAME_W-1:0] link_frame;
  logic [ENTRY_W-1:0] leaf_value;
  logic               out_free;

  // walk datapath
  always_comb begin
    case (lvl)
      2'd0:    lvl_idx = vpn[4*IDX_W-1:3*IDX_W];
      2'd1:    lvl_idx = vpn[3*IDX_W-1:2*IDX_W];
      2'd2:    lvl_idx = vpn[2*IDX_W-1:IDX_W];
      default: lvl_idx = vpn[IDX_W-1:0];
    endcase
    ent_present = rd_data[ENT_P_BIT];
    rel         = rd_data[PAGE_SHIFT +: FRAME_W] - base_frame;
    slot_ok     = rel < FRAME_W'(next_free);
    miss_count  = LVL_COUNT - lvl;
    pool_ok     = ({1'b0, next_free} + (CNT_W+1)'(miss_count)) <= (CNT_W+1)'(TABLE_PAGES);
    link_frame  = base_frame + FRAME_W'(next_free);
    leaf_value  = ({{(ENTRY_W-FRAME_W-PAGE_SHIFT){1'b0}}, frame, {PAGE_SHIFT{1'b0}}})
                  | (flags & LEAF_FLAG_MASK);
    out_free    = !out_valid || rsp.ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:   if (req.valid) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_CHECK;
      S_CHECK: begin
        if (ent_present) begin
          if (!slot_ok)                  state_next = S_RESP;
          else if (lvl == LVL_LAST_UPPER) state_next = S_LEAF;
          else                           state_next = S_LOOKUP;
        end else begin
          state_next = pool_ok ? S_LINK : S_RESP;
        end
      end
      S_LINK:   if (lvl == LVL_LAST_UPPER) state_next = S_LEAF;
      S_LEAF:   state_next = S_RESP;
      S_RESP:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur, lvl_idx};
    mem_wdata = '0;
    mem_raddr = {cur, lvl_idx};
    req.ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_IDLE:  req.ready = 1'b1;
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = ({{(ENTRY_W-FRAME_W-PAGE_SHIFT){1'b0}}, link_frame,
                      {PAGE_SHIFT{1'b0}}}) | TABLE_LINK_FLAGS;
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = {cur, vpn[IDX_W-1:0]};
        mem_wdata = leaf_value;
      end
      S_LOOKUP, S_CHECK, S_RESP: ;
      default: ;
    endcase
  end

  // table store, one read and one write address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      base_frame <= '0;
      next_free  <= CNT_W'(1);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        base_frame <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == S_LINK) begin
        next_free <= next_free + CNT_W'(1);
      end
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        vpn   <= req.virt_page;
        frame <= req.phys_frame;
        flags <= req.leaf_flags;
        lvl   <= '0;
        cur   <= '0;
        need  <= '0;
        err   <= 1'b0;
      end
      S_CHECK: begin
        if (ent_present) begin
          if (!slot_ok) begin
            err <= 1'b1;
          end else begin
            cur <= rel[SLOT_W-1:0];
            lvl <= lvl + 2'd1;
          end
        end else begin
          need <= miss_count;
          err  <= !pool_ok;
        end
      end
      S_LINK: begin
        cur <= next_free[SLOT_W-1:0];
        lvl <= lvl + 2'd1;
      end
      S_RESP: begin
        if (out_free) begin
          out_status     <= err ? STATUS_FULL : STATUS_OK;
          out_new_tables <= err ? '0 : need;
          out_leaf       <= err ? '0 : leaf_value;
        end
      end
      S_CLEAR, S_LOOKUP, S_LEAF: ;
      default: ;
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.new_tables = out_new_tables;
  assign rsp.leaf_entry = out_leaf;

  a_pool_bounds: assert property (@(posedge clk) disable iff (rst)
    next_free >= CNT_W'(1) && next_free <= CNT_W'(TABLE_PAGES))
    else $error("table pool counter out of range");

  a_pool_only_in_link: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && next_free != $past(next_free)) |-> $past(state) == S_LINK)
    else $error("table pool moved outside a link write");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready)
    else $error("item taken during store clear");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_FULL) |-> (rsp.new_tables == '0 && rsp.leaf_entry == '0))
    else $error("error result carries data");

  a_link_after_pool_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> (next_free < CNT_W'(TABLE_PAGES)))
    else $error("table link with empty pool");

endmodule

`default_nettype wire

// File: tb/sv/tb_four_level_page_table_mapper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_mapper
// maps pages through the walker and checks every result against a shadow
// copy of the radix table, covering wrapped and moved root frames, remaps,
// stray table pointers and pool exhaustion, with random stalls on both sides
// ----------------------------------------------------------------------------

module tb_four_level_page_table_mapper;
  import ptm_pkg::*;

  localparam int TABLE_PAGES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
  localparam logic [VPN_W-1:0] VPN_MAX = {VPN_W{1'b1}};
  localparam logic [ENTRY_W-1:0] FLAGS_ALL = {ENTRY_W{1'b1}};

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] new_tables;
    logic [ENTRY_W-1:0] leaf_entry;
  } map_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [FRAME_W-1:0] cfg_wr_data;

  ptm_req_if req_ch ();
  ptm_rsp_if rsp_ch ();

  four_level_page_table_mapper #(
    .TABLE_PAGES(TABLE_PAGES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch.sink),
    .rsp        (rsp_ch.source)
  );

  logic [ENTRY_W-1:0] shadow_tables [0:TABLE_PAGES*ENTRIES_PER_TABLE-1];
  int                 shadow_next_free;
  logic [FRAME_W-1:0] shadow_base;
  map_result_t        pending_results [$];
  logic [VPN_W-1:0]   mapped_pages [$];
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;
  bit                 calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // shadow walker
  function automatic int slot_for(input logic [ENTRY_W-1:0] entry);
    logic [FRAME_W-1:0] rel;
    rel = entry[PAGE_SHIFT +: FRAME_W] - shadow_base;
    if (rel >= FRAME_W'(shadow_next_free) || rel >= FRAME_W'(TABLE_PAGES)) return -1;
    return int'(rel);
  endfunction

  function automatic map_result_t predict_mapping(input logic [VPN_W-1:0] vpn,
                                                  input logic [FRAME_W-1:0] frame,
                                                  input logic [ENTRY_W-1:0] flags);
    int                 idx [4];
    int                 cur;
    int                 need;
    int                 s;
    int                 at;
    bit                 bad;
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] f;
    map_result_t        r;
    idx[0] = int'(vpn[35:27]);
    idx[1] = int'(vpn[26:18]);
    idx[2] = int'(vpn[17:9]);
    idx[3] = int'(vpn[8:0]);
    cur = 0;
    need = 0;
    bad = 1'b0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      e = shadow_tables[cur*ENTRIES_PER_TABLE + idx[lvl]];
      if (e[ENT_P_BIT]) begin
        s = slot_for(e);
        if (s < 0) begin
          bad = 1'b1;
          break;
        end
        cur = s;
      end else begin
        need = 3 - lvl;
        break;
      end
    end
    if (bad || shadow_next_free + need > TABLE_PAGES) begin
      r.status = STATUS_FULL;
      r.new_tables = '0;
      r.leaf_entry = '0;
      return r;
    end
    cur = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      at = cur*ENTRIES_PER_TABLE + idx[lvl];
      e = shadow_tables[at];
      if (e[ENT_P_BIT]) begin
        cur = slot_for(e);
      end else begin
        s = shadow_next_free;
        f = shadow_base + FRAME_W'(s);
        shadow_next_free = s + 1;
        shadow_tables[at] = {{(ENTRY_W-FRAME_W-PAGE_SHIFT){1'b0}}, f, {PAGE_SHIFT{1'b0}}}
                            | TABLE_LINK_FLAGS;
        cur = s;
      end
    end
    e = {{(ENTRY_W-FRAME_W-PAGE_SHIFT){1'b0}}, frame, {PAGE_SHIFT{1'b0}}}
        | (flags & LEAF_FLAG_MASK);
    shadow_tables[cur*ENTRIES_PER_TABLE + idx[3]] = e;
    r.status = STATUS_OK;
    r.new_tables = COUNT_W'(need);
    r.leaf_entry = e;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [ENTRY_W-1:0] want,
                               input logic [ENTRY_W-1:0] got);
    if (got !== want) note_failure($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  task automatic check_result();
    map_result_t want;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("unexpected item status %0b new_tables %0d leaf %0h",
                             rsp_ch.status, rsp_ch.new_tables, rsp_ch.leaf_entry));
    end else begin
      want = pending_results.pop_front();
      compare_field("status", ENTRY_W'(want.status), ENTRY_W'(rsp_ch.status));
      compare_field("new_tables", ENTRY_W'(want.new_tables), ENTRY_W'(rsp_ch.new_tables));
      compare_field("leaf_entry", want.leaf_entry, rsp_ch.leaf_entry);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  task automatic map_page(input logic [VPN_W-1:0] vpn, input logic [FRAME_W-1:0] frame,
                          input logic [ENTRY_W-1:0] flags);
    map_result_t want;
    if (!calm && $urandom_range(99) < 24) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 24) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.virt_page  <= vpn;
    req_ch.phys_frame <= frame;
    req_ch.leaf_flags <= flags;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want = predict_mapping(vpn, frame, flags);
    pending_results.push_back(want);
    if (want.status == STATUS_OK) mapped_pages.push_back(vpn);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [FRAME_W-1:0] frame);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= frame;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_base = frame;
  endtask

  function automatic logic [FRAME_W-1:0] rand_frame();
    return FRAME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_flags();
    return {$urandom, $urandom};
  endfunction

  // mostly walks that reuse tables already built, with some fresh pages
  function automatic logic [VPN_W-1:0] pick_page();
    int               roll;
    logic [VPN_W-1:0] known;
    logic [VPN_W-1:0] fresh;
    fresh = VPN_W'({$urandom, $urandom});
    roll = $urandom_range(99);
    if (mapped_pages.size() == 0 || roll >= 92) return fresh;
    known = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
    if (roll < 15) return known;
    if (roll < 60) return {known[35:9], fresh[8:0]};
    if (roll < 78) return {known[35:18], fresh[17:0]};
    return {known[35:27], fresh[26:0]};
  endfunction

  task automatic map_random_pages(input int count);
    for (int i = 0; i < count; i++) map_page(pick_page(), rand_frame(), rand_flags());
  endtask

  task automatic test_walk_extremes();
    write_table_base(FRAME_MAX);
    map_page('0, '0, '0);
    map_page('0, FRAME_MAX, FLAGS_ALL);
    map_page(VPN_MAX, 40'h12_3456_789A, 64'h80);
    map_page(36'h0_0004_0000, FRAME_MAX, 64'h8000_0000_0000_0007);
    map_page(36'h0_0000_0200, 40'h1, 64'hFFFF_FFFF_FFFF_FF7F);
    map_page(36'h0_0000_0001, 40'h80_0000_0000, 64'h2);
    map_page(36'h0_0000_01FF, '0, FLAGS_ALL);
    map_page(36'h0_0800_0000, rand_frame(), rand_flags());
    map_page(36'h8_0000_0000, rand_frame(), rand_flags());
    map_page(VPN_MAX, '0, '0);
  endtask

  task automatic test_random_mapping();
    for (int i = 0; i < 950; i++) begin
      calm = (i >= 300 && i < 520);
      if (i == 450 || i == 760) drain_results();
      map_page(pick_page(), rand_frame(), rand_flags());
    end
    calm = 1'b0;
  endtask

  // moving the root leaves old pointers stray or shifted
  task automatic test_base_change();
    write_table_base('0);
    map_page('0, rand_frame(), rand_flags());
    map_page(VPN_MAX, rand_frame(), rand_flags());
    map_page(36'h0_0000_0001, rand_frame(), rand_flags());
    map_random_pages(150);
    write_table_base(rand_frame());
    map_page('0, rand_frame(), rand_flags());
    map_page(VPN_MAX, rand_frame(), rand_flags());
    map_page(36'h0_0800_0000, rand_frame(), rand_flags());
    map_page(36'h4_0000_0000, rand_frame(), rand_flags());
    map_random_pages(100);
  endtask

  task automatic test_pool_exhaustion();
    write_table_base(FRAME_MAX);
    for (int i = 0; i < 25; i++) begin
      map_page(VPN_W'({$urandom, $urandom}), rand_frame(), rand_flags());
    end
    map_random_pages(120);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.virt_page  = '0;
    req_ch.phys_frame = '0;
    req_ch.leaf_flags = '0;
    for (int i = 0; i < TABLE_PAGES*ENTRIES_PER_TABLE; i++) shadow_tables[i] = '0;
    shadow_next_free = 1;
    shadow_base      = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);

    test_walk_extremes();
    test_random_mapping();
    test_base_change();
    test_pool_exhaustion();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
